FILE: rtl/i2cee_pkg.sv
// Package for the I2C EEPROM master: item kinds, phases and the front/back queue entry.
// No dependencies.
package i2cee_pkg;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_DEVW, PH_ADDRH, PH_ADDRL, PH_WAITDATA, PH_DATA,
    PH_RSTART, PH_DEVR, PH_GET, PH_MACK, PH_NAK, PH_STOP
  } phase_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DEV_NACK = 2'd1;
  localparam logic [1:0] ST_DAT_NACK = 2'd2;

  typedef struct packed {
    kind_e       kind;
    logic        is_read;
    logic [15:0] memory_address;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_level;
  } item_t;

endpackage

FILE: rtl/i2cee_front.sv
// Front end: accepts stream items, classifies the kind and queues them in a two-entry FIFO.
// Depends on i2cee_pkg.
module i2cee_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [47:0]        data_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output i2cee_pkg::item_t   q_item_o
);
  import i2cee_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  item_t      in_item;
  logic       push, pop;

  always_comb begin
    in_item.kind           = kind_e'(data_i[1:0]);
    in_item.is_read        = data_i[2];
    in_item.memory_address = data_i[18:3];
    in_item.byte_count     = data_i[34:19];
    in_item.write_byte     = data_i[42:35];
    in_item.sda_level      = data_i[43];
  end

  assign ready_o   = (cnt_q != 2'd2);
  assign push      = valid_i && ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/i2cee_back.sv
// Back end: bus sequencer that executes queued items and registers one result per item.
// Depends on i2cee_pkg.
module i2cee_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         dev_addr_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  i2cee_pkg::item_t   q_item_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [15:0]        m_data_o
);
  import i2cee_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  tc_q, tc_d;
  logic [3:0]  bi_q, bi_d;
  logic [7:0]  sh_q, sh_d;
  logic [15:0] left_q, left_d, addr_q, addr_d;
  logic        rm_q, rm_d, pv_q, pv_d, scl_q, scl_d, sda_q, sda_d;
  logic [7:0]  pb_q, pb_d;
  logic [1:0]  st_q, st_d;
  logic        ov_q;
  logic [15:0] od_q;
  logic        rv, dn;
  logic [7:0]  rb;
  logic        take;
  logic [2:0]  len;
  logic [3:0]  bnext;
  logic [2:0]  p, tcn;
  logic [7:0]  shn;

  assign q_ready_o = !ov_q || m_ready_i;
  assign take      = q_valid_i && q_ready_o;
  assign m_valid_o = ov_q;
  assign m_data_o  = od_q;

  always_comb begin
    phase_d = phase_q; tc_d = tc_q; bi_d = bi_q; sh_d = sh_q;
    left_d = left_q; addr_d = addr_q; rm_d = rm_q; pv_d = pv_q; pb_d = pb_q;
    scl_d = scl_q; sda_d = sda_q; st_d = st_q;
    rv = 1'b0; rb = 8'd0; dn = 1'b0;
    len = 3'd5; bnext = 4'd0; p = 3'd0; tcn = 3'd0; shn = 8'd0;
    unique case (q_item_i.kind)
      KIND_BEGIN: begin
        if (phase_q == PH_IDLE) begin
          rm_d = q_item_i.is_read; addr_d = q_item_i.memory_address;
          left_d = q_item_i.byte_count; st_d = ST_OK; pv_d = 1'b0;
          phase_d = PH_START; tc_d = 3'd0; bi_d = 4'd0; sh_d = 8'd0;
        end
      end
      KIND_DATA: begin
        pb_d = q_item_i.write_byte; pv_d = 1'b1;
      end
      KIND_TICK: begin
        if (!(phase_q == PH_WAITDATA && !pv_q)) begin
          if (phase_q == PH_WAITDATA) begin
            phase_d = PH_DATA; tc_d = 3'd0; bi_d = 4'd0; sh_d = pb_q; pv_d = 1'b0;
          end
          p = tc_d;
          tcn = p + 3'd1;
          unique case (phase_d)
            PH_START, PH_RSTART: begin
              len = (bi_d == 4'd2) ? 3'd3 : 3'd5;
              sda_d = (bi_d == 4'd0);
              scl_d = (bi_d != 4'd2);
              tc_d = tcn;
              if (tcn >= len) begin
                tc_d = 3'd0;
                bnext = bi_d + 4'd1;
                bi_d = bnext;
                if (bnext >= 4'd3) begin
                  bi_d = 4'd0;
                  if (phase_d == PH_START) begin
                    phase_d = PH_DEVW; sh_d = dev_addr_i;
                  end else begin
                    phase_d = PH_DEVR; sh_d = dev_addr_i | 8'h01;
                  end
                end
              end
            end
            PH_DEVW, PH_ADDRH, PH_ADDRL, PH_DATA, PH_DEVR: begin
              if (p == 3'd0) sda_d = (bi_d < 4'd8) ? sh_d[7] : 1'b1;
              scl_d = (p == 3'd1 || p == 3'd2);
              if (bi_d >= 4'd8 && p == 3'd2 && q_item_i.sda_level) begin
                if (phase_d == PH_DEVW) st_d = ST_DEV_NACK;
                else if (phase_d == PH_DATA) st_d = ST_DAT_NACK;
              end
              tc_d = tcn;
              if (tcn >= 3'd5) begin
                tc_d = 3'd0;
                if (bi_d < 4'd8) begin
                  sh_d = {sh_d[6:0], 1'b0}; bi_d = bi_d + 4'd1;
                end else begin
                  bi_d = 4'd0; sh_d = 8'd0;
                  priority case (phase_d)
                    PH_DEVW: begin
                      if (st_d == ST_DEV_NACK) phase_d = PH_STOP;
                      else begin phase_d = PH_ADDRH; sh_d = addr_q[15:8]; end
                    end
                    PH_ADDRH: begin phase_d = PH_ADDRL; sh_d = addr_q[7:0]; end
                    PH_ADDRL: begin
                      if (rm_q) phase_d = PH_RSTART;
                      else if (left_q == 16'd0) phase_d = PH_STOP;
                      else phase_d = PH_WAITDATA;
                    end
                    PH_DATA: begin
                      if (st_d == ST_DAT_NACK) phase_d = PH_STOP;
                      else begin
                        left_d = left_q - 16'd1;
                        phase_d = (left_d == 16'd0) ? PH_STOP : PH_WAITDATA;
                      end
                    end
                    default: phase_d = (left_q != 16'd0) ? PH_GET : PH_NAK;
                  endcase
                end
              end
            end
            PH_GET: begin
              sda_d = 1'b1; scl_d = (p < 3'd2);
              shn = sh_d;
              if (p == 3'd1) shn = {sh_d[6:0], q_item_i.sda_level};
              sh_d = shn;
              tc_d = tcn;
              if (tcn >= 3'd4) begin
                tc_d = 3'd0; bi_d = bi_d + 4'd1;
                if (bi_d >= 4'd8) begin
                  rv = 1'b1; rb = shn;
                  left_d = left_q - 16'd1;
                  phase_d = (left_d != 16'd0) ? PH_MACK : PH_NAK;
                  bi_d = 4'd0; sh_d = 8'd0;
                end
              end
            end
            PH_MACK: begin
              sda_d = 1'b0; scl_d = (p < 3'd4); tc_d = tcn;
              if (tcn >= 3'd6) begin phase_d = PH_GET; tc_d = 3'd0; bi_d = 4'd0; sh_d = 8'd0; end
            end
            PH_NAK: begin
              sda_d = 1'b1; scl_d = (p < 3'd2); tc_d = tcn;
              if (tcn >= 3'd4) begin phase_d = PH_STOP; tc_d = 3'd0; bi_d = 4'd0; sh_d = 8'd0; end
            end
            PH_STOP: begin
              sda_d = (p >= 3'd4); scl_d = (p >= 3'd2); tc_d = tcn;
              if (tcn >= 3'd6) begin
                phase_d = PH_IDLE; tc_d = 3'd0; bi_d = 4'd0; sh_d = 8'd0; dn = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; tc_q <= '0; bi_q <= '0; sh_q <= '0; left_q <= '0;
      addr_q <= '0; rm_q <= 1'b0; pv_q <= 1'b0; pb_q <= '0;
      scl_q <= 1'b1; sda_q <= 1'b1; st_q <= ST_OK; ov_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d; tc_q <= tc_d; bi_q <= bi_d; sh_q <= sh_d; left_q <= left_d;
        addr_q <= addr_d; rm_q <= rm_d; pv_q <= pv_d; pb_q <= pb_d;
        scl_q <= scl_d; sda_q <= sda_d; st_q <= st_d;
        ov_q <= 1'b1;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      od_q <= {st_d, dn, (phase_d != PH_IDLE), rv, rb,
               (phase_d == PH_WAITDATA && !pv_d), sda_d, scl_d};
    end
  end
endmodule

FILE: rtl/i2c_eeprom_master.sv
// Top level of the I2C EEPROM master: front queue, bus sequencer and config register.
// Depends on i2cee_pkg, i2cee_front and i2cee_back.
// An accepted item is written into the two-entry queue; its result is registered when
// the item leaves the queue. Throughput: one item per cycle while the output is not
// stalled. Reset clears the sequencer to idle, lines released, device address 0xA0.
module i2c_eeprom_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind, is_read, memory_address, byte_count, write_byte, sda_level
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_release, sda_release, need_byte, read_byte, read_valid, busy_res, done_res, status
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import i2cee_pkg::*;

  logic       qv, qr;
  item_t      qi;
  logic [7:0] dev_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dev_q <= 8'hA0;
    else if (cfg_valid_i) dev_q <= cfg_data_i;
  end

  i2cee_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready), .data_i(s_axis_tdata),
    .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qi)
  );

  i2cee_back u_back (
    .clk_i, .rst_ni, .dev_addr_i(dev_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qi),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_o(m_axis_tdata)
  );
endmodule

FILE: verif/i2c_eeprom_master_chk.sv
// Checker for the I2C EEPROM master: watches the input, output and config channels.
// Predicts every output transaction from its own copy of the sequencer; depends on i2cee_pkg.
module i2c_eeprom_master_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output int          err_cnt_o,
  output int          outstanding_o
);
  import i2cee_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic       done;
    logic       busy;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       need;
    logic       sda;
    logic       scl;
  } bus_res_t;

  bus_res_t   bus_q[$];
  logic [7:0] dev_addr;
  phase_e     ph;
  int         tcnt, bidx;
  logic [7:0] shreg, pend_byte;
  logic [15:0] left_cnt, addr_hold;
  logic       rmode, pend_vld, scl_q, sda_q;
  logic [1:0] stat;

  task automatic enter(input phase_e nph, input logic [7:0] b);
    ph = nph;
    tcnt = 0;
    bidx = 0;
    shreg = b;
  endtask

  task automatic after_send();
    case (ph)
      PH_DEVW:  if (stat == ST_DEV_NACK) enter(PH_STOP, 8'h00);
                else enter(PH_ADDRH, addr_hold[15:8]);
      PH_ADDRH: enter(PH_ADDRL, addr_hold[7:0]);
      PH_ADDRL: if (rmode) enter(PH_RSTART, 8'h00);
                else if (left_cnt == 0) enter(PH_STOP, 8'h00);
                else enter(PH_WAITDATA, 8'h00);
      PH_DATA: begin
        if (stat == ST_DAT_NACK) enter(PH_STOP, 8'h00);
        else begin
          left_cnt = left_cnt - 1;
          if (left_cnt == 0) enter(PH_STOP, 8'h00);
          else enter(PH_WAITDATA, 8'h00);
        end
      end
      default:  if (left_cnt != 0) enter(PH_GET, 8'h00);
                else enter(PH_NAK, 8'h00);
    endcase
  endtask

  task automatic bus_tick(input logic sin, output logic rv, output logic [7:0] rb,
                          output logic dn);
    int p;
    int len;
    rv = 0;
    rb = 0;
    dn = 0;
    if (ph == PH_WAITDATA) begin
      if (!pend_vld) return;
      enter(PH_DATA, pend_byte);
      pend_vld = 0;
    end
    p = tcnt;
    case (ph)
      PH_START, PH_RSTART: begin
        len = (bidx == 2) ? 3 : 5;
        sda_q = (bidx == 0);
        scl_q = (bidx < 2);
        tcnt++;
        if (tcnt >= len) begin
          tcnt = 0;
          bidx++;
          if (bidx >= 3) begin
            if (ph == PH_START) enter(PH_DEVW, dev_addr);
            else enter(PH_DEVR, dev_addr | 8'h01);
          end
        end
      end
      PH_DEVW, PH_ADDRH, PH_ADDRL, PH_DATA, PH_DEVR: begin
        if (p == 0) sda_q = (bidx < 8) ? shreg[7] : 1'b1;
        scl_q = (p == 1 || p == 2);
        if (bidx >= 8 && p == 2 && sin) begin
          if (ph == PH_DEVW) stat = ST_DEV_NACK;
          else if (ph == PH_DATA) stat = ST_DAT_NACK;
        end
        tcnt++;
        if (tcnt >= 5) begin
          tcnt = 0;
          if (bidx < 8) begin
            shreg = shreg << 1;
            bidx++;
          end else after_send();
        end
      end
      PH_GET: begin
        sda_q = 1;
        scl_q = (p < 2);
        if (p == 1) shreg = {shreg[6:0], sin};
        tcnt++;
        if (tcnt >= 4) begin
          tcnt = 0;
          bidx++;
          if (bidx >= 8) begin
            rv = 1;
            rb = shreg;
            left_cnt = left_cnt - 1;
            if (left_cnt != 0) enter(PH_MACK, 8'h00);
            else enter(PH_NAK, 8'h00);
          end
        end
      end
      PH_MACK: begin
        sda_q = 0;
        scl_q = (p < 4);
        tcnt++;
        if (tcnt >= 6) enter(PH_GET, 8'h00);
      end
      PH_NAK: begin
        sda_q = 1;
        scl_q = (p < 2);
        tcnt++;
        if (tcnt >= 4) enter(PH_STOP, 8'h00);
      end
      PH_STOP: begin
        sda_q = (p >= 4);
        scl_q = (p >= 2);
        tcnt++;
        if (tcnt >= 6) begin
          enter(PH_IDLE, 8'h00);
          dn = 1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict(input logic [47:0] d);
    bus_res_t r;
    logic rv, dn;
    logic [7:0] rb;
    rv = 0;
    rb = 0;
    dn = 0;
    case (kind_e'(d[1:0]))
      KIND_BEGIN: if (ph == PH_IDLE) begin
        rmode = d[2];
        addr_hold = d[18:3];
        left_cnt = d[34:19];
        stat = ST_OK;
        pend_vld = 0;
        enter(PH_START, 8'h00);
      end
      KIND_DATA: begin
        pend_byte = d[42:35];
        pend_vld = 1;
      end
      KIND_TICK: bus_tick(d[43], rv, rb, dn);
      default: ;
    endcase
    r.scl = scl_q;
    r.sda = sda_q;
    r.need = (ph == PH_WAITDATA) && !pend_vld;
    r.rd_byte = rv ? rb : 8'h00;
    r.rd_valid = rv;
    r.busy = (ph != PH_IDLE);
    r.done = dn;
    r.status = stat;
    bus_q.push_back(r);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_cnt_o++;
  endtask

  task automatic compare(input bus_res_t g);
    bus_res_t e;
    if (bus_q.size() == 0) begin
      report("unexpected output transaction", g, 0);
      return;
    end
    e = bus_q.pop_front();
    if (g.scl != e.scl) report("scl_release", g.scl, e.scl);
    if (g.sda != e.sda) report("sda_release", g.sda, e.sda);
    if (g.need != e.need) report("need_byte", g.need, e.need);
    if (g.rd_byte != e.rd_byte) report("read_byte", g.rd_byte, e.rd_byte);
    if (g.rd_valid != e.rd_valid) report("read_valid", g.rd_valid, e.rd_valid);
    if (g.busy != e.busy) report("busy_res", g.busy, e.busy);
    if (g.done != e.done) report("done_res", g.done, e.done);
    if (g.status != e.status) report("status", g.status, e.status);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr = 8'hA0;
      enter(PH_IDLE, 8'h00);
      left_cnt = 0;
      addr_hold = 0;
      rmode = 0;
      pend_byte = 0;
      pend_vld = 0;
      scl_q = 1;
      sda_q = 1;
      stat = ST_OK;
      bus_q.delete();
      err_cnt_o = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) dev_addr = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) compare(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) predict(s_axis_tdata);
      outstanding_o <= bus_q.size();
    end
  end

endmodule

FILE: verif/i2c_eeprom_master_tb.sv
// Testbench top for the I2C EEPROM master: clock, reset, stimulus and verdict.
// Depends on i2cee_pkg, i2c_eeprom_master and i2c_eeprom_master_chk.
module i2c_eeprom_master_tb;
  import i2cee_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  int          err_cnt, outstanding;
  int          idle_pct = 0, stall_pct = 0;
  int          done_cnt = 0, need_cnt = 0, item_cnt = 0, cycle_cnt = 0;

  i2c_eeprom_master i_dut (.*);

  i2c_eeprom_master_chk i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .err_cnt_o(err_cnt), .outstanding_o(outstanding)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    if (m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tdata[13]) done_cnt <= done_cnt + 1;
      if (m_axis_tdata[2]) need_cnt <= need_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1500000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(input kind_e k, input logic rd, input logic [15:0] addr,
                      input logic [15:0] cnt, input logic [7:0] wb, input logic sda);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'h0, sda, wb, cnt, addr, rd, k};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    item_cnt++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [7:0] v);
    settle();
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  // drive one bus transaction to its STOP; the slave answers on sda_level
  task automatic run_txn(input logic rd, input logic [15:0] addr, input logic [15:0] cnt,
                         input int nack_pct, input int noise_pct);
    int target, needs;
    target = done_cnt + 1;
    needs = need_cnt;
    send(KIND_BEGIN, rd, addr, cnt, 8'h00, 1'b0);
    while (done_cnt < target) begin
      if (need_cnt != needs) begin
        needs = need_cnt;
        send(KIND_DATA, 1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
             1'($urandom));
      end else if ($urandom_range(99) < noise_pct) begin
        send(kind_e'($urandom_range(3) == 0 ? KIND_NONE :
                     $urandom_range(1) ? KIND_DATA : KIND_BEGIN),
             1'($urandom), 16'($urandom), 16'($urandom_range(4)), 8'($urandom),
             1'($urandom));
      end else begin
        send(KIND_TICK, 1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
             $urandom_range(99) < nack_pct);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(KIND_TICK, 0, 0, 0, 0, 1);
    send(KIND_NONE, 1, 16'hFFFF, 16'hFFFF, 8'hFF, 1);
    send(KIND_DATA, 0, 0, 0, 8'hFF, 0);
    run_txn(0, 16'hFFFF, 1, 0, 0);
    run_txn(1, 16'h0000, 2, 40, 0);
    run_txn(0, 16'h0000, 0, 0, 0);
    run_txn(1, 16'hFFFF, 0, 0, 0);
    write_cfg(8'h00);
    run_txn(0, 16'h1234, 2, 100, 0);
    write_cfg(8'hFE);
    run_txn(1, 16'hA5A5, 1, 60, 0);
    for (int k = 0; k < 4 || item_cnt < 1800; k++) begin
      case (k % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      write_cfg(8'($urandom_range(254)));
      run_txn(1'($urandom), 16'($urandom), 16'($urandom_range(4)),
              $urandom_range(1) ? 5 : 30, 4);
    end
    settle();
    if (err_cnt == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
